@@ sv/crcpp_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-8 record patcher package
// Function and status codes, register reset value and the CRC-8 byte step.
// ----------------------------------------------------------------------------
package crcpp_pkg;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_status;

    localparam t_func FUNC_LOAD  = 2'd0;
    localparam t_func FUNC_GET   = 2'd1;
    localparam t_func FUNC_SET   = 2'd2;
    localparam t_func FUNC_WRITE = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_BAD   = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    localparam logic [3:0] FLAGS_OFFSET_RESET = 4'd11;
    localparam logic [7:0] CRC_POLY           = 8'h07;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ sv/crc_protected_record_patcher.sv @@
// ----------------------------------------------------------------------------
// CRC-8 protected record patcher
// Loads a record byte by byte, checks its CRC-8, reads and patches the flags
// word or single bytes, and streams the whole record back after a change.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | func, byte_in, last_byte, offset,
//          |           |                           | flag_values, flag_mask
//  out     | output    | o_out_valid / i_out_ready | status, flags_out, byte_out,
//          |           |                           | write_out, last_out
//  cfg     | input     | i_cfg_valid / o_cfg_ready | flags_offset (i_cfg_data)
//
//  One item at a time; the record RAM read port walks one byte per cycle unless the output stalls.
//  Synchronous active-low reset; the record RAM has no reset and needs no pass.
//  A stalled output holds the write-back walk; the next item is taken while
//  the final result still waits.
// ----------------------------------------------------------------------------
module crc_protected_record_patcher #(
    parameter int RECORD_MAX = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  crcpp_pkg::t_func   i_func,
    input  logic [7:0]         i_byte_in,
    input  logic               i_last_byte,
    input  logic [3:0]         i_offset,
    input  logic [31:0]        i_flag_values,
    input  logic [31:0]        i_flag_mask,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output crcpp_pkg::t_status o_status,
    output logic [31:0]        o_flags_out,
    output logic [7:0]         o_byte_out,
    output logic               o_write_out,
    output logic               o_last_out
);

    import crcpp_pkg::*;

    localparam int IW = $clog2(RECORD_MAX);
    localparam int LW = $clog2(RECORD_MAX + 2);
    localparam int CW = (LW > 5) ? LW : 5;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WSTART = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_FRD    = 3'd3;
    localparam logic [2:0] S_FCHK   = 3'd4;
    localparam logic [2:0] S_FWR    = 3'd5;
    localparam logic [2:0] S_BRD    = 3'd6;
    localparam logic [2:0] S_RESP   = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [LW-1:0] r_len, n_len;
    logic          r_good, n_good;
    logic [3:0]    r_fo;
    logic [IW-1:0] r_idx, n_idx;
    logic [1:0]    r_k, n_k;
    logic [7:0]    r_crc, n_crc;
    logic [31:0]   r_word, n_word;
    t_status       r_status, n_status;
    logic          r_wb, n_wb;
    logic          r_set, n_set;
    logic [31:0]   r_mask, n_mask;
    logic [31:0]   r_nflags, n_nflags;
    logic [7:0]    r_byte, n_byte;
    logic [3:0]    r_offset, n_offset;

    logic          r_out_valid;
    t_status       r_o_status;
    logic [31:0]   r_o_flags;
    logic [7:0]    r_o_byte;
    logic          r_o_write;
    logic          r_o_last;

    logic          out_load;
    t_status       out_status;
    logic [31:0]   out_flags;
    logic [7:0]    out_byte;
    logic          out_write;
    logic          out_last;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          w_free;
    logic          w_last;
    logic [LW-1:0] w_cnt_inc;
    logic [31:0]   w_nw;

    crcpp_rec_ram #(
        .DEPTH (RECORD_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_free      = !r_out_valid || i_out_ready;
    assign w_last      = (r_idx == IW'(r_len - LW'(1)));
    assign w_cnt_inc   = (r_cnt <= LW'(RECORD_MAX)) ? (r_cnt + LW'(1)) : r_cnt;
    assign w_nw        = (r_word & ~r_mask) | (r_nflags & r_mask);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_good     = r_good;
        n_idx      = r_idx;
        n_k        = r_k;
        n_crc      = r_crc;
        n_word     = r_word;
        n_status   = r_status;
        n_wb       = r_wb;
        n_set      = r_set;
        n_mask     = r_mask;
        n_nflags   = r_nflags;
        n_byte     = r_byte;
        n_offset   = r_offset;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        out_load   = 1'b0;
        out_status = ST_OK;
        out_flags  = '0;
        out_byte   = '0;
        out_write  = 1'b0;
        out_last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_word = '0;
                    if (i_func == FUNC_LOAD) begin
                        n_good = 1'b0;
                        if (r_cnt < LW'(RECORD_MAX)) begin
                            ram_we    = 1'b1;
                            ram_waddr = IW'(r_cnt);
                            ram_wdata = i_byte_in;
                        end
                        if (!i_last_byte) begin
                            n_cnt = w_cnt_inc;
                        end else begin
                            n_len = w_cnt_inc;
                            n_cnt = '0;
                            if (w_cnt_inc > LW'(RECORD_MAX)) begin
                                n_status = ST_BAD;
                                n_state  = S_RESP;
                            end else begin
                                n_wb    = 1'b0;
                                n_state = S_WSTART;
                            end
                        end
                    end else if (!r_good) begin
                        n_status = ST_BAD;
                        n_state  = S_RESP;
                    end else if (i_func == FUNC_WRITE) begin
                        if (CW'(i_offset) >= CW'(r_len) - CW'(1)) begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = IW'(i_offset);
                            n_byte    = i_byte_in;
                            n_offset  = i_offset;
                            n_state   = S_BRD;
                        end
                    end else begin
                        if (CW'(r_len) < CW'(r_fo) + CW'(4)) begin
                            n_status = ST_BAD;
                            n_state  = S_RESP;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = IW'(r_fo);
                            n_k       = 2'd0;
                            n_set     = (i_func == FUNC_SET);
                            n_mask    = i_flag_mask;
                            n_nflags  = i_flag_values;
                            n_state   = S_FRD;
                        end
                    end
                end
            end
            S_WSTART: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_idx     = '0;
                n_crc     = '0;
                n_state   = S_WALK;
            end
            S_WALK: begin
                if (!r_wb) begin
                    if (w_last) begin
                        n_good   = (ram_rdata == r_crc);
                        n_status = (ram_rdata == r_crc) ? ST_OK : ST_BAD;
                        n_word   = '0;
                        n_state  = S_RESP;
                    end else begin
                        n_crc     = crc8_byte(r_crc, ram_rdata);
                        n_idx     = r_idx + IW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + IW'(1);
                    end
                end else if (w_free) begin
                    out_load  = 1'b1;
                    out_write = 1'b1;
                    out_last  = w_last;
                    if (w_last) begin
                        out_byte  = r_crc;
                        ram_we    = 1'b1;
                        ram_waddr = r_idx;
                        ram_wdata = r_crc;
                        n_state   = S_IDLE;
                    end else begin
                        out_byte  = ram_rdata;
                        n_crc     = crc8_byte(r_crc, ram_rdata);
                        n_idx     = r_idx + IW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + IW'(1);
                    end
                end
            end
            S_FRD: begin
                n_word = {ram_rdata, r_word[31:8]};
                if (r_k != 2'd3) begin
                    ram_re    = 1'b1;
                    ram_raddr = IW'(CW'(r_fo) + CW'(r_k) + CW'(1));
                    n_k       = r_k + 2'd1;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_FCHK: begin
                n_status = ST_OK;
                if (!r_set) begin
                    n_state = S_RESP;
                end else if (w_nw == r_word) begin
                    n_word  = '0;
                    n_state = S_RESP;
                end else begin
                    n_word  = w_nw;
                    n_k     = 2'd0;
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(CW'(r_fo) + CW'(r_k));
                ram_wdata = r_word[7:0];
                n_word    = {8'h00, r_word[31:8]};
                n_k       = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_wb    = 1'b1;
                    n_state = S_WSTART;
                end
            end
            S_BRD: begin
                if (ram_rdata == r_byte) begin
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(r_offset);
                    ram_wdata = r_byte;
                    n_wb      = 1'b1;
                    n_state   = S_WSTART;
                end
            end
            S_RESP: begin
                if (w_free) begin
                    out_load   = 1'b1;
                    out_status = r_status;
                    out_flags  = r_word;
                    out_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_len       <= '0;
            r_good      <= 1'b0;
            r_fo        <= FLAGS_OFFSET_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_good  <= n_good;
            if (i_cfg_valid) begin
                r_fo <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_crc    <= n_crc;
        r_word   <= n_word;
        r_status <= n_status;
        r_wb     <= n_wb;
        r_set    <= n_set;
        r_mask   <= n_mask;
        r_nflags <= n_nflags;
        r_byte   <= n_byte;
        r_offset <= n_offset;
        if (out_load) begin
            r_o_status <= out_status;
            r_o_flags  <= out_flags;
            r_o_byte   <= out_byte;
            r_o_write  <= out_write;
            r_o_last   <= out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_flags_out = r_o_flags;
    assign o_byte_out  = r_o_byte;
    assign o_write_out = r_o_write;
    assign o_last_out  = r_o_last;

endmodule

@@ sv/crcpp_rec_ram.sv @@
// ----------------------------------------------------------------------------
// Record byte store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module crcpp_rec_ram #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
